FILE: sv/packed_code_match_counter_defines.svh
// ----------------------------------------------------------------------------
// Packed code match counter assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PACKED_CODE_MATCH_COUNTER_DEFINES_SVH
`define PACKED_CODE_MATCH_COUNTER_DEFINES_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define PCMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcmc assertion failed");
// Checked on every edge, reset included.
`define PCMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcmc assertion failed");
`else
`define PCMC_ASSERT(label, clk, rst_n, prop)
`define PCMC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: sv/pcmc_pkg.sv
// ----------------------------------------------------------------------------
// Packed code match counter package
// Shared widths, limits, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package pcmc_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_WINDOW = 65536;
    localparam int SUM_W      = 17;
    localparam int CNT_W      = 6;
    localparam int OFS_W      = 5;
    localparam int IDX_W      = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    // Window cap as seen through the 17-bit window register
    localparam logic [SUM_W-1:0] WIN_CAP =
        (MAX_WINDOW > 131071) ? SUM_MAX : SUM_W'(MAX_WINDOW);

    typedef enum logic [IDX_W-1:0] {
        CFG_CODE_WIDTH = 3'd0,
        CFG_START_OFS  = 3'd1,
        CFG_END_OFS    = 3'd2,
        CFG_WINDOW     = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       code_width_log2;
        logic [OFS_W-1:0] start_offset;
        logic [OFS_W-1:0] end_offset;
        logic [SUM_W-1:0] window_size;
    } t_cfg;

endpackage

FILE: sv/pcmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Packed code match counter configuration registers
// Holds code width, window offsets and window size; writes out of range drop.
// ----------------------------------------------------------------------------
module pcmc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [pcmc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [pcmc_pkg::SUM_W-1:0]  i_cfg_data,
    output pcmc_pkg::t_cfg              o_cfg
);

    pcmc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_width_log2 <= 2'd1;
            r_cfg.start_offset    <= '0;
            r_cfg.end_offset      <= '1;
            r_cfg.window_size     <= pcmc_pkg::SUM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (pcmc_pkg::t_cfg_idx'(i_cfg_index))
                pcmc_pkg::CFG_CODE_WIDTH: r_cfg.code_width_log2 <= i_cfg_data[1:0];
                pcmc_pkg::CFG_START_OFS:  r_cfg.start_offset <=
                    i_cfg_data[pcmc_pkg::OFS_W-1:0];
                pcmc_pkg::CFG_END_OFS:    r_cfg.end_offset <=
                    i_cfg_data[pcmc_pkg::OFS_W-1:0];
                pcmc_pkg::CFG_WINDOW:     r_cfg.window_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/pcmc_code_count.sv
// ----------------------------------------------------------------------------
// Packed code match counter code counter
// Flags nonzero codes of an XOR word, masks by offsets, and counts them.
// ----------------------------------------------------------------------------
module pcmc_code_count (
    input  logic [pcmc_pkg::WORD_BITS-1:0] i_diff,
    input  logic [1:0]                     i_width_log2,
    input  logic [pcmc_pkg::OFS_W-1:0]     i_start,
    input  logic [pcmc_pkg::OFS_W-1:0]     i_end,
    input  logic                           i_first,
    input  logic                           i_last,
    output logic [pcmc_pkg::CNT_W-1:0]     o_count
);

    localparam int W = pcmc_pkg::WORD_BITS;

    logic [W-1:0]              w_f1;
    logic [W/2-1:0]            w_f2;
    logic [W/4-1:0]            w_f4;
    logic [W/8-1:0]            w_f8;
    logic [W-1:0]              w_flags;
    logic [W-1:0]              w_keep;
    logic [W-1:0]              w_hit;
    logic [pcmc_pkg::OFS_W-1:0] w_cpw_m1;
    logic [pcmc_pkg::OFS_W-1:0] w_hi;
    logic [pcmc_pkg::OFS_W-1:0] w_lo;
    logic [1:0]                w_p2 [16];
    logic [2:0]                w_p3 [8];
    logic [3:0]                w_p4 [4];
    logic [4:0]                w_p5 [2];

    // Per-width nonzero flags, LSB-first code order
    always_comb begin
        w_f1 = i_diff;
        for (int i = 0; i < W/2; i++) w_f2[i] = |i_diff[2*i +: 2];
        for (int i = 0; i < W/4; i++) w_f4[i] = |i_diff[4*i +: 4];
        for (int i = 0; i < W/8; i++) w_f8[i] = |i_diff[8*i +: 8];
    end

    always_comb begin
        unique case (i_width_log2)
            2'd0:    w_flags = w_f1;
            2'd1:    w_flags = W'(w_f2);
            2'd2:    w_flags = W'(w_f4);
            default: w_flags = W'(w_f8);
        endcase
    end

    // Code j (MSB-first) is LSB-first code cpw-1-j
    assign w_cpw_m1 = 5'h1F >> i_width_log2;
    assign w_hi     = w_cpw_m1 - (i_start & w_cpw_m1);
    assign w_lo     = w_cpw_m1 - (i_end & w_cpw_m1);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            w_keep[i] = (!i_first || (pcmc_pkg::OFS_W'(i) <= w_hi)) &&
                        (!i_last  || (pcmc_pkg::OFS_W'(i) >= w_lo));
        end
    end

    assign w_hit = w_flags & w_keep;

    // Adder tree popcount
    always_comb begin
        for (int i = 0; i < 16; i++) w_p2[i] = {1'b0, w_hit[2*i]} + {1'b0, w_hit[2*i+1]};
        for (int i = 0; i < 8; i++)  w_p3[i] = {1'b0, w_p2[2*i]} + {1'b0, w_p2[2*i+1]};
        for (int i = 0; i < 4; i++)  w_p4[i] = {1'b0, w_p3[2*i]} + {1'b0, w_p3[2*i+1]};
        for (int i = 0; i < 2; i++)  w_p5[i] = {1'b0, w_p4[2*i]} + {1'b0, w_p4[2*i+1]};
    end

    assign o_count = {1'b0, w_p5[0]} + {1'b0, w_p5[1]};

endmodule

FILE: sv/packed_code_match_counter.sv
// ----------------------------------------------------------------------------
// Packed code match counter
// Counts matching packed codes between a query and a column over a window.
// ----------------------------------------------------------------------------
// One word pair is taken per cycle unless a last word waits for room in the
// output register: the XOR of the pair lands in an input register, the offset
// mask and popcount feed one accumulator add, and the count for a window sits
// in an output register until taken. Throughput is set by that single
// accumulator stage; the output register lets the next window's words up to
// its last keep flowing while a result waits. Registers may be written only
// while no window is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "packed_code_match_counter_defines.svh"

module packed_code_match_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcmc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [pcmc_pkg::SUM_W-1:0]     i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pcmc_pkg::WORD_BITS-1:0] i_query_word,
    input  logic [pcmc_pkg::WORD_BITS-1:0] i_column_word,
    input  logic                           i_first_word,
    input  logic                           i_last_word,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pcmc_pkg::SUM_W-1:0]     o_equal_count
);

    localparam int SW = pcmc_pkg::SUM_W;

    pcmc_pkg::t_cfg                 w_cfg;
    logic                           r_a_valid;
    logic                           r_a_first;
    logic                           r_a_last;
    logic [pcmc_pkg::WORD_BITS-1:0] r_a_diff;
    logic [SW-1:0]                  r_sum;
    logic                           r_out_valid;
    logic [SW-1:0]                  r_equal_count;

    logic                           w_out_free;
    logic                           w_a_adv;
    logic [pcmc_pkg::CNT_W-1:0]     w_count;
    logic [SW-1:0]                  w_base;
    logic [SW:0]                    w_sum_ext;
    logic [SW-1:0]                  w_sum_sat;
    logic [SW-1:0]                  w_win;
    logic [SW-1:0]                  n_sum;
    logic [SW-1:0]                  n_equal_count;

    pcmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pcmc_code_count u_count (
        .i_diff       (r_a_diff),
        .i_width_log2 (w_cfg.code_width_log2),
        .i_start      (w_cfg.start_offset),
        .i_end        (w_cfg.end_offset),
        .i_first      (r_a_first),
        .i_last       (r_a_last),
        .o_count      (w_count)
    );

    assign o_cfg_ready = 1'b1;

    // Only last words need room in the output register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_a_adv    = r_a_valid && (!r_a_last || w_out_free);
    assign o_in_ready = !r_a_valid || w_a_adv;

    assign w_base    = r_a_first ? '0 : r_sum;
    assign w_sum_ext = {1'b0, w_base} + (SW+1)'(w_count);
    assign w_sum_sat = w_sum_ext[SW] ? pcmc_pkg::SUM_MAX : w_sum_ext[SW-1:0];
    assign n_sum     = r_a_last ? '0 : w_sum_sat;

    assign w_win = (w_cfg.window_size > pcmc_pkg::WIN_CAP) ? pcmc_pkg::WIN_CAP
                                                           : w_cfg.window_size;
    assign n_equal_count = (w_win > w_sum_sat) ? (w_win - w_sum_sat) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (w_a_adv) begin
                r_sum <= n_sum;
            end
            if (w_a_adv && r_a_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a_diff  <= i_query_word ^ i_column_word;
            r_a_first <= i_first_word;
            r_a_last  <= i_last_word;
        end
        if (w_a_adv && r_a_last) begin
            r_equal_count <= n_equal_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_equal_count = r_equal_count;

    `PCMC_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !o_out_valid)
    `PCMC_ASSERT(a_sum_clear_after_last, i_clk, i_rst_n, (w_a_adv && r_a_last) |=> (r_sum == '0))
    `PCMC_ASSERT(a_out_from_last, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(w_a_adv && r_a_last))
    `PCMC_ASSERT(a_count_in_window, i_clk, i_rst_n, o_out_valid |-> (o_equal_count <= pcmc_pkg::WIN_CAP))

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed code match counter testbench
// Drives word pairs through the valid/ready input port and takes match counts
// from the output port. A software tally of the XOR, offset masks and running
// mismatch count predicts each count not set by a typed directed row. A short
// directed table leads; random windows follow over several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES = 4;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int PHASE_WORDS  = 70;
    localparam int N_PHASES     = 6;
    localparam int N_DIR        = 20;
    localparam logic [pcmc_pkg::IDX_W-1:0] FIRST_NO_REG =
        pcmc_pkg::IDX_W'(pcmc_pkg::CFG_WINDOW) + 1'b1;

    typedef struct packed {
        bit                         set_cfg;
        logic [1:0]                 cw;
        logic [pcmc_pkg::OFS_W-1:0] so;
        logic [pcmc_pkg::OFS_W-1:0] eo;
        logic [pcmc_pkg::SUM_W-1:0] win;
        logic [31:0]                q;
        logic [31:0]                c;
        bit                         first;
        bit                         last;
        bit                         typed;
        logic [pcmc_pkg::SUM_W-1:0] want;
    } t_dir_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [pcmc_pkg::IDX_W-1:0]       i_cfg_index = '0;
    logic [pcmc_pkg::SUM_W-1:0]       i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [pcmc_pkg::WORD_BITS-1:0]   i_query_word = '0;
    logic [pcmc_pkg::WORD_BITS-1:0]   i_column_word = '0;
    logic                             i_first_word = 1'b0;
    logic                             i_last_word = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [pcmc_pkg::SUM_W-1:0]       o_equal_count;

    // register copy and running mismatch count of the predictor
    pcmc_pkg::t_cfg cfg_model = '{code_width_log2: 2'd1, start_offset: '0,
                                  end_offset: '1, window_size: pcmc_pkg::SUM_W'(1)};
    int unsigned                 acc_mismatches = 0;
    logic [pcmc_pkg::SUM_W-1:0]  equal_counts_due [$];
    int                          n_fail = 0;
    int                          in_idle_pct = 0;
    int                          out_idle_pct = 0;

    t_dir_row dir_rows [N_DIR] = '{
        '{0, 0, 0,  0,      0, 32'h0000_0000, 32'h0000_0000, 1, 1, 1,     1},
        '{0, 0, 0,  0,      0, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1,     0},
        '{1, 0, 0, 31,     32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1,    32},
        '{0, 0, 0,  0,      0, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1,     0},
        '{1, 3, 1,  2,      4, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 0,     0},
        '{1, 2, 31, 0,     10, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1,    10},
        '{0, 0, 0,  0,      0, 32'h1234_5678, 32'h8765_4321, 1, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 0, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'h0000_0000, 32'h8000_0001, 0, 1, 0,     0},
        '{1, 1, 5, 10, 131071, 32'h0000_0000, 32'h0000_0000, 1, 1, 1, 65536},
        '{1, 1, 5, 10,  65536, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1, 0,     0},
        '{1, 1, 5, 10,      0, 32'h0000_0000, 32'h0000_0000, 1, 1, 1,     0},
        '{1, 0, 0, 31,    100, 32'hF0F0_F0F0, 32'h0000_0000, 0, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'h0000_0001, 32'h0000_0000, 0, 1, 0,     0},
        '{0, 0, 0,  0,      0, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'h0000_FFFF, 32'h0000_0000, 1, 0, 0,     0},
        '{0, 0, 0,  0,      0, 32'h0000_0000, 32'h0000_0001, 0, 1, 0,     0},
        '{1, 3, 3,  0,      7, 32'hFF00_0000, 32'h0000_0000, 1, 1, 1,     7},
        '{1, 3, 0,  3,      4, 32'h0102_0304, 32'h0000_0000, 1, 1, 1,     0}
    };

    packed_code_match_counter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_query_word (i_query_word),
        .i_column_word(i_column_word),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_equal_count(o_equal_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Mask, count differing codes and accumulate; returns 1 when a count is due.
    function automatic bit tally_word(input logic [31:0] q, input logic [31:0] c,
                                      input bit first, input bit last,
                                      output logic [pcmc_pkg::SUM_W-1:0] count);
        int unsigned bpc, cpw, s, e, n, win;
        logic [31:0] diff, code_mask;
        bpc = 1 << cfg_model.code_width_log2;
        cpw = pcmc_pkg::WORD_BITS / bpc;
        s = cfg_model.start_offset & (cpw - 1);
        e = cfg_model.end_offset & (cpw - 1);
        diff = q ^ c;
        count = '0;
        if (first) begin
            acc_mismatches = 0;
            diff &= 32'hFFFF_FFFF >> (s * bpc);
        end
        if (last) begin
            diff &= 32'hFFFF_FFFF << ((cpw - 1 - e) * bpc);
        end
        code_mask = (32'h1 << bpc) - 1;
        n = 0;
        for (int k = 0; k < cpw; k++) begin
            if (((diff >> (k * bpc)) & code_mask) != 0) n++;
        end
        acc_mismatches += n;
        if (acc_mismatches > pcmc_pkg::SUM_MAX) acc_mismatches = pcmc_pkg::SUM_MAX;
        if (!last) return 1'b0;
        win = (cfg_model.window_size > pcmc_pkg::MAX_WINDOW) ? pcmc_pkg::MAX_WINDOW
                                                             : cfg_model.window_size;
        count = (win > acc_mismatches) ? pcmc_pkg::SUM_W'(win - acc_mismatches) : '0;
        acc_mismatches = 0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] column_for(input logic [31:0] q);
        case ($urandom_range(0, 3))
            0: return q;
            1: return $urandom;
            2: return q ^ (32'h1 << $urandom_range(0, 31));
            default: return q ^ ($urandom & $urandom & $urandom);
        endcase
    endfunction

    // valid stays high after a transfer; the next call lowers it only to idle
    task automatic send_word(input logic [31:0] q, input logic [31:0] c,
                             input bit first, input bit last,
                             input bit typed, input logic [pcmc_pkg::SUM_W-1:0] want);
        logic [pcmc_pkg::SUM_W-1:0] count;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_query_word  <= q;
        i_column_word <= c;
        i_first_word  <= first;
        i_last_word   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (tally_word(q, c, first, last, count)) begin
            equal_counts_due.push_back(typed ? want : count);
        end
    endtask

    task automatic send_window(input int len);
        logic [31:0] q;
        for (int i = 0; i < len; i++) begin
            q = $urandom;
            send_word(q, column_for(q), i == 0, i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic write_reg(input logic [pcmc_pkg::IDX_W-1:0] idx,
                             input logic [pcmc_pkg::SUM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pcmc_pkg::CFG_CODE_WIDTH: cfg_model.code_width_log2 = data[1:0];
            pcmc_pkg::CFG_START_OFS:  cfg_model.start_offset = data[pcmc_pkg::OFS_W-1:0];
            pcmc_pkg::CFG_END_OFS:    cfg_model.end_offset = data[pcmc_pkg::OFS_W-1:0];
            pcmc_pkg::CFG_WINDOW:     cfg_model.window_size = data;
            default: ;
        endcase
    endtask

    // lower input valid, wait out every pending count and the pipeline tail
    task automatic drain();
        i_in_valid <= 1'b0;
        while (equal_counts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] cw, input logic [pcmc_pkg::OFS_W-1:0] so,
                              input logic [pcmc_pkg::OFS_W-1:0] eo,
                              input logic [pcmc_pkg::SUM_W-1:0] win);
        // a write to an unmapped index must leave everything alone
        write_reg(pcmc_pkg::IDX_W'($urandom_range(FIRST_NO_REG, {pcmc_pkg::IDX_W{1'b1}})),
                  pcmc_pkg::SUM_W'($urandom));
        write_reg(pcmc_pkg::CFG_CODE_WIDTH, pcmc_pkg::SUM_W'(cw));
        write_reg(pcmc_pkg::CFG_START_OFS, pcmc_pkg::SUM_W'(so));
        write_reg(pcmc_pkg::CFG_END_OFS, pcmc_pkg::SUM_W'(eo));
        write_reg(pcmc_pkg::CFG_WINDOW, win);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_words);
        int sent, len;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                          1'b0, '0);
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                send_window(len);
                sent += len;
            end
        end
        // close any window left open by noise words
        send_window($urandom_range(1, 3));
    endtask

    function automatic logic [pcmc_pkg::SUM_W-1:0] pick_window();
        case ($urandom_range(0, 5))
            0: return pcmc_pkg::SUM_W'(pcmc_pkg::MAX_WINDOW);
            1: return pcmc_pkg::SUM_MAX;
            2: return '0;
            3: return pcmc_pkg::SUM_W'($urandom);
            default: return pcmc_pkg::SUM_W'($urandom_range(1, 200));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (equal_counts_due.size() == 0) begin
                $error("equal_count: no result expected, actual %0d", o_equal_count);
                n_fail++;
            end else begin
                if (o_equal_count !== equal_counts_due[0]) begin
                    $error("equal_count: expected %0d, actual %0d",
                           equal_counts_due[0], o_equal_count);
                    n_fail++;
                end
                void'(equal_counts_due.pop_front());
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 36;
        out_idle_pct = 46;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg) begin
                drain();
                set_config(dir_rows[i].cw, dir_rows[i].so, dir_rows[i].eo, dir_rows[i].win);
            end
            send_word(dir_rows[i].q, dir_rows[i].c, dir_rows[i].first, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p < 2) begin
                in_idle_pct  = 36;
                out_idle_pct = 46;
            end else if (p < 4) begin
                in_idle_pct  = 46;
                out_idle_pct = 36;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            case (p)
                0: set_config(2'd0, '0, '1, pcmc_pkg::SUM_W'($urandom_range(1, 200)));
                1: set_config(2'd3, '1, '1, pcmc_pkg::SUM_MAX);
                default: set_config(2'($urandom), pcmc_pkg::OFS_W'($urandom),
                                    pcmc_pkg::OFS_W'($urandom), pick_window());
            endcase
            random_phase(PHASE_WORDS);
        end

        drain();
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
